### design/prrsa_pkg.sv
`default_nettype none
package prrsa_pkg;

	// default router geometry
	localparam int PORTS_DEF        = 5;
	localparam int PACKET_FLITS_DEF = 4;

	// byte-padded width of a bus carrying the given number of payload bits
	function automatic int byte_pad(input int bits);
		byte_pad = ((bits + 7) / 8) * 8;
	endfunction

endpackage
`default_nettype wire

### design/prrsa_out_arb.sv
`default_nettype none
module prrsa_out_arb
	import prrsa_pkg::*;
#(
	parameter int PORTS        = PORTS_DEF,
	parameter int PACKET_FLITS = PACKET_FLITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [PORTS-1:0] col_req,
	input  wire logic             full,
	output logic      [PORTS-1:0] grant_col
);

	localparam int PTR_W = $clog2(PORTS);
	localparam int CNT_W = (PACKET_FLITS > 1) ? $clog2(PACKET_FLITS) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PORTS - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PACKET_FLITS - 1);

	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] ptr_next;
	logic [CNT_W-1:0] cnt_next;
	logic             asks;
	logic             last;

	always_comb begin
		asks = col_req[ptr_q];
		last = (cnt_q == CNT_LAST);
		if (asks) begin
			cnt_next = last ? '0 : cnt_q + CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
		// move on after the last flit, or when the pointed input is idle between packets
		if (last || (!asks && cnt_q == '0)) begin
			ptr_next = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
		end else begin
			ptr_next = ptr_q;
		end
		grant_col = '0;
		grant_col[ptr_q] = asks && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			ptr_q <= ptr_next;
			cnt_q <= cnt_next;
		end
	end

endmodule
`default_nettype wire

### design/packet_round_robin_switch_allocator.sv
// Round-robin switch allocator for a mesh router, one allocation per transfer.
// Slave stream: s_axis_tdata carries request_matrix (PORTS*PORTS bits, bit
// in*PORTS+out means input in wants output out) and then output_full (PORTS
// bits, one per output). Master stream: m_axis_tdata carries grant_matrix in
// the same bit layout, at most one grant per output column.
// Each output keeps a priority pointer and a flit counter; only the pointed
// input can win, and the pointer moves on at packet ends or idle boundaries.
// Pipeline: a request accepted on the slave side is registered, allocated by
// single-pass logic against the per-output pointers, and its grant is loaded
// into the output register, which drives m_axis_tvalid; a full output register
// holds the allocation back until the receiver takes its grant.
// Throughput: one transfer per cycle on both sides unless the receiver stalls;
// the state of every output is updated in the cycle its grant is registered.
// Receiver stall: the output register holds its grant, the input register
// holds one more request, then s_axis_tready falls until the grant is taken.
// Reset (arst_n low): pipeline emptied, all pointers and counters to zero.
`default_nettype none
module packet_round_robin_switch_allocator
	import prrsa_pkg::*;
#(
	parameter int PORTS        = PORTS_DEF,
	parameter int PACKET_FLITS = PACKET_FLITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// request_matrix [PORTS*PORTS-1:0], output_full, zero pad
	input  wire logic [byte_pad(PORTS*PORTS+PORTS)-1:0] s_axis_tdata,
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// grant_matrix [PORTS*PORTS-1:0], zero pad
	output logic      [byte_pad(PORTS*PORTS)-1:0]       m_axis_tdata
);

	localparam int MAT_W = PORTS * PORTS;
	localparam int OUT_W = byte_pad(PORTS * PORTS);

	logic             v_s1;
	logic [MAT_W-1:0] req_s1;
	logic [PORTS-1:0] full_s1;
	logic             v_s2;
	logic [MAT_W-1:0] grant_s2;
	logic             advance;
	logic [MAT_W-1:0] grant;
	logic [PORTS-1:0] col_req [PORTS];
	logic [PORTS-1:0] grant_col [PORTS];

	assign advance       = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || advance;
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = OUT_W'(grant_s2);

	for (genvar o = 0; o < PORTS; o++) begin : g_out
		for (genvar i = 0; i < PORTS; i++) begin : g_in
			assign col_req[o][i]      = req_s1[i*PORTS + o];
			assign grant[i*PORTS + o] = grant_col[o][i];
		end
		prrsa_out_arb #(
			.PORTS        (PORTS),
			.PACKET_FLITS (PACKET_FLITS)
		) u_arb (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (advance),
			.col_req   (col_req[o]),
			.full      (full_s1[o]),
			.grant_col (grant_col[o])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= s_axis_tdata[MAT_W-1:0];
			full_s1 <= s_axis_tdata[MAT_W+PORTS-1:MAT_W];
		end
		if (advance) begin
			grant_s2 <= grant;
		end
	end

endmodule
`default_nettype wire
